FILE: rtl/stg_pkg.sv
// Shared widths, register codes, reset values and sine table math for the tone generator.
package stg_pkg;

   localparam int TABLE_BITS_DEFAULT = 10;
   localparam int PHASE_BITS_DEFAULT = 32;

   localparam int STEP_W     = 32;
   localparam int AMP_W      = 15;
   localparam int COUNT_W    = 32;
   localparam int SAMPLE_W   = 16;
   localparam int INDEX_W    = 32;
   localparam int MAG_W      = 15;
   localparam int AMP_FRAC   = 15;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = SAMPLE_W + INDEX_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP   = 2'd0,
      CSR_AMPLITUDE    = 2'd1,
      CSR_SAMPLE_COUNT = 2'd2
   } csr_index_type;

   localparam logic [STEP_W-1:0]  PHASE_STEP_RESET   = 32'd97391549;
   localparam logic [AMP_W-1:0]   AMPLITUDE_RESET    = 15'd32767;
   localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 32'd441000;

   // pi/2 in Q2.30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   // (2k)(2k+1) for the Taylor terms of sin
   localparam logic [63:0] TAYLOR_DIV [1:8] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
   };

   // Q0.15 quarter-wave entry idx of a table with 2^quarter_bits steps
   function automatic logic [MAG_W-1:0] table_entry(input int unsigned idx,
                                                    input int unsigned quarter_bits);
      logic [63:0]        theta;
      logic [63:0]        theta2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      theta  = (HALF_PI_Q30 * 64'(idx)) >> quarter_bits;
      theta2 = (theta * theta) >> 30;
      term   = theta;
      sum    = signed'(theta);
      for (int k = 1; k <= 8; k++) begin
         term = ((term * theta2) >> 30) / TAYLOR_DIV[k];
         if ((k % 2) == 1) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum <= 0) begin
         return '0;
      end
      r = (unsigned'(sum) + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[MAG_W-1:0];
   endfunction

endpackage

FILE: rtl/sine_tone_generator.sv
// Top level of the direct digital synthesis sine tone generator.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------------------
//   req_     | in        | req_tvalid/req_tready | tdata[0] restart
//   rsp_     | out       | rsp_tvalid/rsp_tready | tdata sample[15:0], sample_index[47:16]
//            |           |                       | tlast = last sample of the run
//   csr_     | in        | csr_wen               | csr_index, csr_wdata (write only)
//
// One request per clock is sustained while rsp_tready stays high; each result passes the
// synchronous sine ROM read register, then the amplitude multiply into the output register.
// Phase and run index are updated in the cycle a request is taken, so requests follow
// back to back with no interlock.
// Reset (synchronous, active high) clears phase, index and both pipeline stages and
// loads the register reset values; the ROM is constant and needs no clearing pass.
// A stalled result holds in the output register while one more request still enters the
// ROM stage; only when both stages are full does req_tready drop.
module sine_tone_generator #(
   parameter int TABLE_BITS = stg_pkg::TABLE_BITS_DEFAULT,
   parameter int PHASE_BITS = stg_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [stg_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] restart, rest zero
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [stg_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [15:0] sample, [47:16] sample_index
   output logic                             rsp_tlast,
   // register write port
   input  logic                             csr_wen,
   input  logic [stg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [stg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import stg_pkg::*;

   localparam int QUARTER_BITS  = TABLE_BITS - 2;
   localparam int QUARTER_STEPS = 1 << QUARTER_BITS;
   localparam int ROM_ADDR_W    = TABLE_BITS - 1;

   typedef logic [MAG_W-1:0] rom_type [0:QUARTER_STEPS];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int i = 0; i <= QUARTER_STEPS; i++) begin
         rom[i] = table_entry(unsigned'(i), unsigned'(QUARTER_BITS));
      end
      return rom;
   endfunction

   // Quarter-wave sine ROM, one synchronous read port
   localparam rom_type SINE_ROM = build_rom();

   // configuration
   logic [STEP_W-1:0]     phase_step_ff;
   logic [AMP_W-1:0]      amplitude_ff;
   logic [COUNT_W-1:0]    sample_count_ff;

   // oscillator state
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [INDEX_W-1:0]    index_ff, index_in;

   // ROM stage
   logic                  s1_valid_ff;
   logic                  s1_neg_ff;
   logic                  s1_last_ff;
   logic [INDEX_W-1:0]    s1_index_ff;
   logic [MAG_W-1:0]      rom_data_ff;

   // output register
   logic                  rsp_tvalid_ff;
   logic                  rsp_last_ff;
   logic [SAMPLE_W-1:0]   rsp_sample_ff, rsp_sample_in;
   logic [INDEX_W-1:0]    rsp_index_ff;

   // stage 0 signals
   logic                  req_fire;
   logic                  out_en;
   logic                  s1_en;
   logic [PHASE_BITS-1:0] s0_phase;
   logic [INDEX_W-1:0]    s0_index;
   logic                  s0_last;
   logic [TABLE_BITS-1:0] s0_addr;
   logic [1:0]            s0_quad;
   logic [ROM_ADDR_W-1:0] s0_j;
   logic [ROM_ADDR_W-1:0] rom_addr;

   logic [AMP_W+MAG_W-1:0] product;
   logic [MAG_W-1:0]       scaled;

   // Each stage advances when its successor is empty or draining
   assign out_en     = !rsp_tvalid_ff || rsp_tready;
   assign s1_en      = !s1_valid_ff || out_en;
   assign req_tready = s1_en;
   assign req_fire   = req_tvalid && req_tready;

   // Restart clears phase and index before this sample is formed
   assign s0_phase = req_tdata[0] ? '0 : phase_ff;
   assign s0_index = req_tdata[0] ? '0 : index_ff;
   assign s0_last  = (s0_index == sample_count_ff);

   // Top phase bits: quadrant and position within the quarter wave
   assign s0_addr  = s0_phase[PHASE_BITS-1 -: TABLE_BITS];
   assign s0_quad  = s0_addr[TABLE_BITS-1 -: 2];
   assign s0_j     = {1'b0, s0_addr[QUARTER_BITS-1:0]};
   // Odd quadrants run the table backward
   assign rom_addr = s0_quad[0] ? (ROM_ADDR_W'(QUARTER_STEPS) - s0_j) : s0_j;

   // End of run restarts at zero, else advance
   assign phase_in = s0_last ? '0 : (s0_phase + PHASE_BITS'(phase_step_ff));
   assign index_in = s0_last ? '0 : (s0_index + INDEX_W'(1));

   // Scale by amplitude and truncate, then apply the sign: truncation toward zero
   assign product       = (AMP_W+MAG_W)'(amplitude_ff) * (AMP_W+MAG_W)'(rom_data_ff);
   assign scaled        = product[AMP_FRAC +: MAG_W];
   assign rsp_sample_in = s1_neg_ff ? (SAMPLE_W'(0) - SAMPLE_W'(scaled)) : SAMPLE_W'(scaled);

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= PHASE_STEP_RESET;
         amplitude_ff    <= AMPLITUDE_RESET;
         sample_count_ff <= SAMPLE_COUNT_RESET;
         phase_ff        <= '0;
         index_ff        <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_PHASE_STEP:   phase_step_ff   <= csr_wdata[STEP_W-1:0];
               CSR_AMPLITUDE:    amplitude_ff    <= csr_wdata[AMP_W-1:0];
               CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[COUNT_W-1:0];
               default: ;  // drop writes to unused indexes
            endcase
         end
         if (req_fire) begin
            phase_ff <= phase_in;
            index_ff <= index_in;
         end
         if (s1_en) begin
            s1_valid_ff <= req_fire;
         end
         if (out_en) begin
            rsp_tvalid_ff <= s1_valid_ff;
         end
      end
   end

   // ROM read and payload registers
   always_ff @(posedge clock) begin
      if (s1_en) begin
         rom_data_ff <= SINE_ROM[rom_addr];
         s1_neg_ff   <= s0_quad[1];
         s1_last_ff  <= s0_last;
         s1_index_ff <= s0_index;
      end
      if (out_en) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_index_ff  <= s1_index_ff;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_index_ff, rsp_sample_ff};
   assign rsp_tlast  = rsp_last_ff;

   // End of run restarts phase and index
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && s0_last) |=> (phase_ff == '0 && index_ff == '0))
      else $error("state not cleared after last sample");

   // Inside a run the index steps by one
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !s0_last) |=> (index_ff == $past(s0_index) + INDEX_W'(1)))
      else $error("run index did not advance by one");

   // A blocked ROM stage keeps its item and its read data
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_en) |=> (s1_valid_ff && $stable(rom_data_ff)
                                    && $stable(s1_index_ff)))
      else $error("ROM stage lost data while stalled");

   // An item leaving the ROM stage lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_en) |=> rsp_tvalid_ff)
      else $error("item dropped between ROM stage and output");

endmodule
